[rtl/assert_macros.svh]
// Assertion helpers for the grid spreader. Each one expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKGS_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKGS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[rtl/skgs_pkg.sv]
package skgs_pkg;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 1'd1;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SPREAD = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [7:0] ROW_RESET = 8'd128;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [2:0]         tap_index;
		logic signed [15:0] x_weight;
		logic signed [15:0] y_weight;
		logic [6:0]         start_x;
		logic [6:0]         start_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] cell_value;
		logic               saturated;
	} out_item_t;

	typedef enum logic [1:0] {
		JOB_LOAD,
		JOB_SPREAD,
		JOB_READ,
		JOB_CLEAR
	} job_kind_t;

	typedef struct packed {
		job_kind_t          kind;
		logic [2:0]         tap;
		logic signed [15:0] xw;
		logic signed [15:0] yw;
		logic [6:0]         sx;
		logic [6:0]         sy;
	} job_t;

	// Effective grid size, already limited to the grid side.
	typedef struct packed {
		logic [7:0] len;
		logic [7:0] cnt;
	} limits_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_SPREAD,
		BK_DRAIN,
		BK_READ,
		BK_READ_WAIT,
		BK_CLEAR
	} back_state_t;

endpackage

[rtl/skgs_ram.sv]
module skgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/skgs_queue.sv]
module skgs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  skgs_pkg::job_t  push_job,
	input  logic            pop,
	output skgs_pkg::job_t  head,
	output logic            full,
	output logic            empty
);

	import skgs_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	job_t            entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   count_q;

	assign full  = (count_q == NW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

[rtl/skgs_front.sv]
module skgs_front #(
	parameter int TAPS      = 8,
	parameter int GRID_SIDE = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  skgs_pkg::in_item_t                    cmd,
	input  logic                                  cfg_we,
	input  logic [skgs_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [skgs_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                  q_full,
	input  logic                                  booting,
	output logic                                  busy,
	output logic                                  q_push,
	output skgs_pkg::job_t                        q_job,
	output skgs_pkg::limits_t                     lim
);

	import skgs_pkg::*;

	localparam int         LIM_MAX = (GRID_SIDE > 255) ? 255 : GRID_SIDE;
	localparam logic [7:0] LIM8    = 8'(LIM_MAX);

	logic [7:0] row_length_q;
	logic [7:0] row_count_q;
	logic       accept;
	logic       keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_RESET;
			row_count_q  <= ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_LENGTH: row_length_q <= cfg_wdata;
				REG_ROW_COUNT:  row_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign lim.len = (row_length_q > LIM8) ? LIM8 : row_length_q;
	assign lim.cnt = (row_count_q > LIM8) ? LIM8 : row_count_q;

	assign busy   = q_full || booting;
	assign accept = start && !busy;

	// Items with no effect (a load past the last tap, a point whose footprint
	// starts off the grid) are dropped here and never reach the back end.
	always_comb begin
		q_job.tap = cmd.tap_index;
		q_job.xw  = cmd.x_weight;
		q_job.yw  = cmd.y_weight;
		q_job.sx  = cmd.start_x;
		q_job.sy  = cmd.start_y;
		case (cmd.opcode)
			OP_LOAD: begin
				q_job.kind = JOB_LOAD;
				keep       = int'(cmd.tap_index) < TAPS;
			end
			OP_SPREAD: begin
				q_job.kind = JOB_SPREAD;
				keep       = ({1'b0, cmd.start_x} < lim.len) && ({1'b0, cmd.start_y} < lim.cnt);
			end
			OP_READ: begin
				q_job.kind = JOB_READ;
				keep       = 1'b1;
			end
			OP_CLEAR: begin
				q_job.kind = JOB_CLEAR;
				keep       = 1'b1;
			end
			default: begin
				q_job.kind = JOB_READ;
				keep       = 1'b0;
			end
		endcase
	end

	assign q_push = accept && keep;

endmodule

[rtl/skgs_back.sv]
module skgs_back #(
	parameter int TAPS      = 8,
	parameter int GRID_SIDE = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skgs_pkg::limits_t     lim,
	input  logic                  q_empty,
	input  skgs_pkg::job_t        q_head,
	output logic                  q_pop,
	output logic                  booting,
	output logic                  done,
	output skgs_pkg::out_item_t   result
);

	import skgs_pkg::*;

	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int TW    = $clog2(TAPS);

	localparam logic [CW-1:0] INIT_LAST = CW'(DEPTH - 1);
	localparam logic [TW-1:0] TAP_LAST  = TW'(TAPS - 1);

	back_state_t state_q, state_d;

	job_t               job_q;
	logic [TW-1:0]      i_q, j_q;
	logic [CW-1:0]      sweep_q, end_q;
	logic [CW-1:0]      sweep_next;
	logic               sat_q;
	logic               rd_ok_q;
	logic               done_q;
	out_item_t          result_q;
	logic signed [15:0] x_taps_q [TAPS];
	logic signed [15:0] y_taps_q [TAPS];

	logic               valid_s1, valid_s2;
	logic [AW-1:0]      addr_s1, addr_s2;
	logic signed [31:0] prod_s1;
	logic [16:0]        add_s2;

	logic               tap_we, step, rd_issue, rd_finish, sweep_en, flag_clr, clr_go;
	logic               i_last, j_last;
	logic [7:0]         x_pos, y_pos;
	logic [15:0]        row_base;
	logic [16:0]        cell_full;
	logic [AW-1:0]      cell_addr;
	logic               in_grid;
	logic [15:0]        clear_cells;
	logic signed [31:0] prod_bias;
	logic [32:0]        sum;
	logic               sat_hit;
	logic [31:0]        sat_sum;

	logic               mem_we, mem_re;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [31:0]        mem_wdata, mem_rdata;

	// Cell address of the current tap pair; i and j are zero for a read.
	assign x_pos     = {1'b0, job_q.sx} + 8'(i_q);
	assign y_pos     = {1'b0, job_q.sy} + 8'(j_q);
	assign row_base  = 16'(y_pos) * 16'(lim.len);
	assign cell_full = {1'b0, row_base} + {9'd0, x_pos};
	assign cell_addr = AW'(cell_full);
	assign in_grid   = (x_pos < lim.len) && (y_pos < lim.cnt);

	assign i_last      = (i_q == TAP_LAST);
	assign j_last      = (j_q == TAP_LAST);
	assign sweep_next  = sweep_q + 1'b1;
	assign clear_cells = 16'(lim.len) * 16'(lim.cnt);

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		tap_we    = 1'b0;
		step      = 1'b0;
		rd_issue  = 1'b0;
		rd_finish = 1'b0;
		sweep_en  = 1'b0;
		flag_clr  = 1'b0;
		clr_go    = 1'b0;
		case (state_q)
			BK_INIT: begin
				sweep_en = 1'b1;
				if (sweep_q == INIT_LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_head.kind)
						JOB_LOAD:   tap_we = 1'b1;
						JOB_SPREAD: state_d = BK_SPREAD;
						JOB_READ:   state_d = BK_READ;
						JOB_CLEAR: begin
							flag_clr = 1'b1;
							clr_go   = 1'b1;
							if (clear_cells != '0) begin
								state_d = BK_CLEAR;
							end
						end
						default: ;
					endcase
				end
			end
			BK_SPREAD: begin
				step = 1'b1;
				if (i_last && j_last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				// The next item may read a cell that is still being written.
				if (!valid_s1 && !valid_s2) begin
					state_d = BK_IDLE;
				end
			end
			BK_READ: begin
				rd_issue = 1'b1;
				state_d  = BK_READ_WAIT;
			end
			BK_READ_WAIT: begin
				rd_finish = 1'b1;
				state_d   = BK_IDLE;
			end
			BK_CLEAR: begin
				sweep_en = 1'b1;
				if (sweep_next == end_q) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			sweep_q  <= '0;
			sat_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
			for (int k = 0; k < TAPS; k++) begin
				x_taps_q[k] <= '0;
				y_taps_q[k] <= '0;
			end
		end else begin
			if (q_pop) begin
				i_q <= '0;
				j_q <= '0;
			end else if (step) begin
				if (i_last) begin
					i_q <= '0;
					j_q <= j_last ? '0 : j_q + 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
			if (clr_go) begin
				sweep_q <= '0;
			end else if (sweep_en) begin
				sweep_q <= sweep_next;
			end
			if (flag_clr) begin
				sat_q <= 1'b0;
			end else if (sat_hit) begin
				sat_q <= 1'b1;
			end
			if (tap_we) begin
				for (int k = 0; k < TAPS; k++) begin
					if (int'(q_head.tap) == k) begin
						x_taps_q[k] <= q_head.xw;
						y_taps_q[k] <= q_head.yw;
					end
				end
			end
			valid_s1 <= step && in_grid;
			valid_s2 <= valid_s1;
			done_q   <= rd_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (clr_go) begin
			end_q <= CW'(clear_cells);
		end
		if (rd_issue) begin
			rd_ok_q <= in_grid;
		end
		if (rd_finish) begin
			result_q.cell_value <= rd_ok_q ? mem_rdata : '0;
			result_q.saturated  <= sat_q;
		end
		addr_s1 <= cell_addr;
		prod_s1 <= 32'(x_taps_q[i_q]) * 32'(y_taps_q[j_q]);
		addr_s2 <= addr_s1;
		add_s2  <= prod_bias[31:15];
	end

	// Round half up from Q2.30 to Q.15: add half an LSB, keep the upper bits.
	assign prod_bias = prod_s1 + 32'sd16384;

	assign sum     = {mem_rdata[31], mem_rdata} + {{16{add_s2[16]}}, add_s2};
	assign sat_hit = valid_s2 && (sum[32] != sum[31]);
	assign sat_sum = (sum[32] != sum[31]) ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)
		: sum[31:0];

	assign mem_we    = sweep_en || valid_s2;
	assign mem_waddr = sweep_en ? sweep_q[AW-1:0] : addr_s2;
	assign mem_wdata = sweep_en ? '0 : sat_sum;
	assign mem_re    = valid_s1 || rd_issue;
	assign mem_raddr = rd_issue ? cell_addr : addr_s1;

	skgs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign booting = (state_q == BK_INIT);
	assign done    = done_q;
	assign result  = result_q;

endmodule

[rtl/separable_kernel_grid_spreader_top.sv]
// Reset clears the taps, the flag and the control state, then sweeps the whole grid memory
// to zero, one cell a cycle, with busy held high. A read is taken from the queue, then passes
// the READ and READ_WAIT states and the result register before its strobe on done. A tap
// load is written as it is popped; a point makes one read-modify-write per cycle in the grid
// memory; a clear zeroes row_length*row_count cells. Two items queue up ahead of the back end.
// Results are shown for one cycle on done and cannot be stalled.
module separable_kernel_grid_spreader_top #(
	parameter int TAPS      = 8,
	parameter int GRID_SIDE = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  skgs_pkg::in_item_t                cmd,
	output logic                              busy,
	input  logic                              cfg_we,
	input  logic [skgs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [skgs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                              done,
	output skgs_pkg::out_item_t               result
);

	import skgs_pkg::*;

	`include "assert_macros.svh"

	logic    q_push, q_pop, q_full, q_empty, booting;
	job_t    q_job, q_head;
	limits_t lim;

	skgs_front #(
		.TAPS      (TAPS),
		.GRID_SIDE (GRID_SIDE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.booting   (booting),
		.busy      (busy),
		.q_push    (q_push),
		.q_job     (q_job),
		.lim       (lim)
	);

	skgs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.pop      (q_pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	skgs_back #(
		.TAPS      (TAPS),
		.GRID_SIDE (GRID_SIDE)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.lim     (lim),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.booting (booting),
		.done    (done),
		.result  (result)
	);

	`SKGS_ASSERT_IMPL(a_push_not_full, q_push, !q_full, "item pushed into a full queue")
	`SKGS_ASSERT_IMPL(a_pop_not_empty, q_pop, !q_empty, "back end popped an empty queue")
	`SKGS_ASSERT_IMPL(a_no_pop_booting, booting, !q_pop, "item taken during the clearing pass")
	`SKGS_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

endmodule

[tb/tb_separable_kernel_grid_spreader_top.sv]
module tb_separable_kernel_grid_spreader_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skgs_pkg::*;

	localparam int TAPS       = 8;
	localparam int GRID_SIDE  = 128;
	localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
	localparam int DRAIN_LIMIT = 200000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	in_item_t               cmd = '0;
	logic                   busy;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   done;
	out_item_t              result;

	// Grid model and its settings, advanced as each item is accepted.
	logic signed [15:0] x_taps_model [TAPS];
	logic signed [15:0] y_taps_model [TAPS];
	logic signed [31:0] grid_model [GRID_CELLS];
	logic               sat_model;
	logic [7:0]         row_length_reg;
	logic [7:0]         row_count_reg;

	in_item_t  cmd_backlog[$];
	out_item_t read_results_due[$];
	out_item_t due_item;
	int        send_idle_pct;
	int        queued_items;
	int        mismatches;

	separable_kernel_grid_spreader_top #(
		.TAPS(TAPS),
		.GRID_SIDE(GRID_SIDE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int grid_limit(logic [7:0] r);
		return (r > GRID_SIDE) ? GRID_SIDE : int'(r);
	endfunction

	// Q1.15 times Q1.15, rounded half up back to Q.15.
	function automatic logic signed [31:0] weight_product(logic signed [15:0] a,
			logic signed [15:0] b);
		longint p;
		p = longint'(a) * longint'(b) + 64'sd16384;
		return 32'(p >>> 15);
	endfunction

	function automatic void update_grid_model(in_item_t c);
		int        len;
		int        cnt;
		int        x;
		int        y;
		longint    s;
		out_item_t r;
		len = grid_limit(row_length_reg);
		cnt = grid_limit(row_count_reg);
		case (c.opcode)
			OP_LOAD: begin
				x_taps_model[c.tap_index] = $signed(c.x_weight);
				y_taps_model[c.tap_index] = $signed(c.y_weight);
			end
			OP_SPREAD: begin
				for (int j = 0; j < TAPS; j++) begin
					y = int'(c.start_y) + j;
					for (int i = 0; i < TAPS; i++) begin
						x = int'(c.start_x) + i;
						if (y < cnt && x < len) begin
							s = longint'(grid_model[y * len + x])
								+ longint'(weight_product(x_taps_model[i], y_taps_model[j]));
							if (s > 64'sd2147483647) begin
								s = 64'sd2147483647;
								sat_model = 1'b1;
							end else if (s < -64'sd2147483648) begin
								s = -64'sd2147483648;
								sat_model = 1'b1;
							end
							grid_model[y * len + x] = 32'(s);
						end
					end
				end
			end
			OP_READ: begin
				r.cell_value = '0;
				if (int'(c.start_x) < len && int'(c.start_y) < cnt)
					r.cell_value = grid_model[int'(c.start_y) * len + int'(c.start_x)];
				r.saturated = sat_model;
				read_results_due.push_back(r);
			end
			default: begin
				for (int k = 0; k < len * cnt; k++)
					grid_model[k] = '0;
				sat_model = 1'b0;
			end
		endcase
	endfunction

	function automatic void queue_cmd(logic [1:0] op, logic [2:0] tap, logic [15:0] xw,
			logic [15:0] yw, logic [6:0] sx, logic [6:0] sy);
		in_item_t c;
		c.opcode    = op;
		c.tap_index = tap;
		c.x_weight  = xw;
		c.y_weight  = yw;
		c.start_x   = sx;
		c.start_y   = sy;
		cmd_backlog.push_back(c);
		queued_items++;
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// Mostly inside the grid, sometimes hugging its far edge, sometimes anywhere.
	function automatic logic [6:0] pick_start(int lim);
		int lo;
		if (lim == 0 || $urandom_range(7) == 0)
			return 7'($urandom_range(127));
		if ($urandom_range(3) == 0) begin
			lo = (lim > TAPS) ? lim - TAPS : 0;
			return 7'($urandom_range(lim - 1, lo));
		end
		return 7'($urandom_range(lim - 1));
	endfunction

	function automatic void add_point_sequence(int len, int cnt);
		logic [6:0] sx;
		logic [6:0] sy;
		if ($urandom_range(4) == 0) begin
			// Partial reload: some taps keep the previous point's weights.
			repeat ($urandom_range(TAPS - 1, 1))
				queue_cmd(OP_LOAD, 3'($urandom_range(TAPS - 1)), pick_weight(), pick_weight(),
					7'($urandom_range(127)), 7'($urandom_range(127)));
		end else begin
			for (int t = 0; t < TAPS; t++)
				queue_cmd(OP_LOAD, 3'(t), pick_weight(), pick_weight(),
					7'($urandom_range(127)), 7'($urandom_range(127)));
		end
		sx = pick_start(len);
		sy = pick_start(cnt);
		queue_cmd(OP_SPREAD, 3'($urandom_range(7)), pick_weight(), pick_weight(), sx, sy);
		if ($urandom_range(2) == 0)
			queue_cmd(OP_SPREAD, 3'($urandom_range(7)), pick_weight(), pick_weight(), sx, sy);
		repeat ($urandom_range(4, 1))
			queue_cmd(OP_READ, 3'($urandom_range(7)), pick_weight(), pick_weight(),
				7'(sx + $urandom_range(TAPS + 1)), 7'(sy + $urandom_range(TAPS + 1)));
	endfunction

	function automatic void fill_random(int goal, int len, int cnt);
		int         pick;
		logic [1:0] op;
		while (queued_items < goal) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				add_point_sequence(len, cnt);
			end else if (pick < 95) begin
				op = 2'($urandom_range(3));
				if (op == OP_CLEAR && $urandom_range(9) != 0)
					op = OP_READ;
				queue_cmd(op, 3'($urandom_range(7)), pick_weight(), pick_weight(),
					7'($urandom_range(127)), 7'($urandom_range(127)));
			end else begin
				queue_cmd(OP_CLEAR, 3'($urandom_range(7)), pick_weight(), pick_weight(),
					7'($urandom_range(127)), 7'($urandom_range(127)));
				queue_cmd(OP_READ, 3'($urandom_range(7)), pick_weight(), pick_weight(),
					pick_start(len), pick_start(cnt));
			end
		end
	endfunction

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROW_LENGTH)
			row_length_reg = val;
		else
			row_count_reg = val;
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		while ((cmd_backlog.size() != 0 || start || read_results_due.size() != 0)
				&& waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
	endtask

	// Each phase ends on a read, so its result arriving means the back end has gone idle.
	task automatic run_phase(logic [7:0] len, logic [7:0] cnt, int idle_pct, int n);
		int lim_l;
		int lim_c;
		int goal;
		write_reg(REG_ROW_LENGTH, len);
		write_reg(REG_ROW_COUNT, cnt);
		lim_l = grid_limit(len);
		lim_c = grid_limit(cnt);
		@(negedge clk);
		send_idle_pct = idle_pct;
		goal = queued_items + n / 2;
		fill_random(goal, lim_l, lim_c);
		wait_drained();
		repeat ($urandom_range(40, 5)) @(negedge clk);
		goal = queued_items + n - n / 2;
		fill_random(goal, lim_l, lim_c);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, pick_start(lim_l), pick_start(lim_c));
		wait_drained();
		repeat (100) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				update_grid_model(cmd);
				void'(cmd_backlog.pop_front());
			end
			// A refused item stays on the port untouched until it is taken.
			if (!(start && busy)) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					start <= 1'b1;
					cmd   <= cmd_backlog[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (read_results_due.size() == 0) begin
				if (mismatches < 10)
					$display("result with no read pending: value %0d sat %0b",
						result.cell_value, result.saturated);
				mismatches++;
			end else begin
				due_item = read_results_due.pop_front();
				if (result.cell_value !== due_item.cell_value
						|| result.saturated !== due_item.saturated) begin
					if (mismatches < 10)
						$display("cell read mismatch: expected %0d sat %0b, got %0d sat %0b",
							due_item.cell_value, due_item.saturated,
							result.cell_value, result.saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		for (int k = 0; k < GRID_CELLS; k++)
			grid_model[k] = '0;
		for (int t = 0; t < TAPS; t++) begin
			x_taps_model[t] = '0;
			y_taps_model[t] = '0;
		end
		sat_model      = 1'b0;
		row_length_reg = ROW_RESET;
		row_count_reg  = ROW_RESET;
		send_idle_pct  = 0;
		queued_items   = 0;
		mismatches     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// The grid memory is swept clean after reset with busy held high.
		repeat (2) @(negedge clk);
		while (busy)
			@(negedge clk);

		// Directed items on the full grid left by reset.
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd0, 7'd0);
		queue_cmd(OP_READ, 3'd7, 16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
		queue_cmd(OP_LOAD, 3'd0, 16'h8000, 16'h8000, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd1, 16'h7FFF, 16'h7FFF, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd2, 16'h8000, 16'h7FFF, 7'd0, 7'd0);
		// Exact halves: one rounds up to 1, the other to 0.
		queue_cmd(OP_LOAD, 3'd3, 16'h0001, 16'h4000, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd4, 16'hFFFF, 16'h4000, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd5, 16'hFFFF, 16'hFFFF, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd6, 16'h7FFF, 16'h0000, 7'd0, 7'd0);
		queue_cmd(OP_LOAD, 3'd7, 16'h0003, 16'hC000, 7'd0, 7'd0);
		queue_cmd(OP_SPREAD, 3'd0, 16'h0000, 16'h0000, 7'd0, 7'd0);
		// Footprints that run off the right and bottom edges.
		queue_cmd(OP_SPREAD, 3'd0, 16'h0000, 16'h0000, 7'd124, 7'd124);
		queue_cmd(OP_SPREAD, 3'd0, 16'h0000, 16'h0000, 7'd127, 7'd0);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd0, 7'd0);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd7, 7'd7);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd3, 7'd5);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd124, 7'd124);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd127, 7'd127);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd127, 7'd0);
		queue_cmd(OP_CLEAR, 3'd0, 16'h0000, 16'h0000, 7'd0, 7'd0);
		queue_cmd(OP_READ, 3'd0, 16'h0000, 16'h0000, 7'd0, 7'd0);
		wait_drained();
		repeat (100) @(negedge clk);

		run_phase(8'd8, 8'd8, 0, 250);
		run_phase(8'd1, 8'd1, 49, 150);
		run_phase(8'd255, 8'd200, 0, 250);
		run_phase(8'd0, 8'd5, 18, 60);
		run_phase(8'd13, 8'd7, 49, 300);
		run_phase(8'd128, 8'd128, 18, 300);
		run_phase(8'd37, 8'd129, 0, 250);
		run_phase(8'd128, 8'd1, 49, 200);
		run_phase(8'd2, 8'd128, 18, 200);

		mismatches += read_results_due.size();
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#50_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
